// ===== rtl/utf8v_pkg.sv =====
// ============================================================================
// UTF-8 validator package
// Decoder state type and the byte and code point limits for UTF-8 checking.
// ============================================================================
package utf8v_pkg;

    // Byte ranges
    localparam logic [7:0] CONT_MASK   = 8'hc0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] ASCII_LIMIT = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hc2;
    localparam logic [7:0] LEAD2_HI    = 8'hdf;
    localparam logic [7:0] LEAD3_LO    = 8'he0;
    localparam logic [7:0] LEAD3_HI    = 8'hef;
    localparam logic [7:0] LEAD4_LO    = 8'hf0;
    localparam logic [7:0] LEAD4_HI    = 8'hf4;

    // Code point limits
    localparam logic [20:0] CP_MIN2      = 21'h000080;
    localparam logic [20:0] CP_MIN3      = 21'h000800;
    localparam logic [20:0] CP_MIN4      = 21'h010000;
    localparam logic [20:0] CP_MAX       = 21'h10ffff;
    localparam logic [20:0] SURROGATE_LO = 21'h00d800;
    localparam logic [20:0] SURROGATE_HI = 21'h00dfff;

    // Lead byte class, for the overlong check
    typedef enum logic [1:0] {
        CLS_NONE  = 2'd0,
        CLS_TWO   = 2'd1,
        CLS_THREE = 2'd2,
        CLS_FOUR  = 2'd3
    } seq_class_t;

    typedef struct packed {
        logic [1:0]  pending;    // continuation bytes still expected
        logic [20:0] code_point; // bits gathered so far
        seq_class_t  seq_class;
        logic        error_seen; // sticky until end of string
    } dec_state_t;

    localparam dec_state_t STATE_CLEAR = '{
        pending:    2'd0,
        code_point: 21'd0,
        seq_class:  CLS_NONE,
        error_seen: 1'b0
    };

    localparam dec_state_t STATE_ERROR = '{
        pending:    2'd0,
        code_point: 21'd0,
        seq_class:  CLS_NONE,
        error_seen: 1'b1
    };

endpackage

// ===== rtl/utf8v_step.sv =====
// ============================================================================
// UTF-8 validator step logic
// Next decoder state and end-of-string verdict for one byte transaction.
// ============================================================================
module utf8v_step (
    input  utf8v_pkg::dec_state_t cur_state,
    input  logic [7:0]            data_byte,
    input  logic                  byte_present,
    input  logic                  end_of_string,
    output utf8v_pkg::dec_state_t next_state,
    output logic                  string_valid
);
    import utf8v_pkg::*;

    dec_state_t  after_byte;
    logic [20:0] cp_shift;
    logic [1:0]  pend_dec;
    logic [20:0] cp_min;
    logic        cp_bad;

    assign cp_shift = {cur_state.code_point[14:0], data_byte[5:0]};
    assign pend_dec = cur_state.pending - 2'd1;

    always_comb begin
        case (cur_state.seq_class)
            CLS_TWO:   cp_min = CP_MIN2;
            CLS_THREE: cp_min = CP_MIN3;
            default:   cp_min = CP_MIN4;
        endcase
    end

    // overlong, out of range, or surrogate
    assign cp_bad = (cp_shift < cp_min) || (cp_shift > CP_MAX)
                 || ((cp_shift >= SURROGATE_LO) && (cp_shift <= SURROGATE_HI));

    always_comb begin
        after_byte = cur_state;
        if (byte_present && !cur_state.error_seen) begin
            if (cur_state.pending != 2'd0) begin
                if ((data_byte & CONT_MASK) != CONT_TAG) begin
                    after_byte = STATE_ERROR;
                end else if (pend_dec == 2'd0) begin
                    after_byte = cp_bad ? STATE_ERROR : STATE_CLEAR;
                end else begin
                    after_byte.pending    = pend_dec;
                    after_byte.code_point = cp_shift;
                end
            end else if (data_byte == 8'h00) begin
                after_byte = STATE_ERROR;
            end else if (data_byte < ASCII_LIMIT) begin
                after_byte = cur_state;
            end else if (data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
                after_byte.pending    = 2'd1;
                after_byte.code_point = {16'd0, data_byte[4:0]};
                after_byte.seq_class  = CLS_TWO;
            end else if (data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
                after_byte.pending    = 2'd2;
                after_byte.code_point = {17'd0, data_byte[3:0]};
                after_byte.seq_class  = CLS_THREE;
            end else if (data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
                after_byte.pending    = 2'd3;
                after_byte.code_point = {18'd0, data_byte[2:0]};
                after_byte.seq_class  = CLS_FOUR;
            end else begin
                after_byte = STATE_ERROR;
            end
        end
    end

    assign string_valid = !after_byte.error_seen && (after_byte.pending == 2'd0);
    assign next_state   = end_of_string ? STATE_CLEAR : after_byte;

endmodule

// ===== rtl/utf8_string_validator.sv =====
// ============================================================================
// UTF-8 string validator
// Checks a byte stream string by string and returns one verdict per string.
// ============================================================================
// Verdict path: input register, then result register, then m_tvalid.
// Throughput: one transaction per cycle; a string end waits on a held result;
//   rate set by the decoder update between the input and state registers.
// Reset: synchronous, active low; clears both valid flags and decoder state.
// ============================================================================
module utf8_string_validator (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] byte_present
    input  logic       s_tlast,   // end_of_string
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] string_valid, [7:1] zero
);
    import utf8v_pkg::*;

    // Input register stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_present_reg;
    logic       in_last_reg;

    // Decoder state
    dec_state_t state_reg;
    dec_state_t state_next;
    logic       verdict;

    // Result register
    logic       out_valid_reg;
    logic       out_data_reg;

    logic       advance;
    logic       s_accept;

    // The staged transaction moves on unless it ends a string and the result
    // slot is still occupied. Transactions without a result never stall.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg    <= s_tdata;
            in_present_reg <= s_tuser;
            in_last_reg    <= s_tlast;
        end
    end

    utf8v_step u_step (
        .cur_state     (state_reg),
        .data_byte     (in_byte_reg),
        .byte_present  (in_present_reg),
        .end_of_string (in_last_reg),
        .next_state    (state_next),
        .string_valid  (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_CLEAR;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    // Verdict register: loads when an end-of-string transaction advances
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_last_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_last_reg) begin
            out_data_reg <= verdict;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg};

endmodule
